[rtl/core/ssf_pkg.sv]
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and defaults for the subset sum finder.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int MAX_CONTACTS_DEF = 64;
  localparam int MAX_SUM_DEF      = 16383;
  localparam int AGE_BITS_DEF     = 8;

  // fixed port field widths
  localparam int IN_AGE_W    = 8;
  localparam int TARGET_W    = 14;
  localparam int OUT_AGE_W   = 8;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 24;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

endpackage

[rtl/core/subset_sum_finder.sv]
// ----------------------------------------------------------------------------
// subset_sum_finder
// Stores ages in load and descending order, answers subset sum queries.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_tready is low until all of its results
// are delivered. A load runs the insertion loop over the sorted age memory.
// A query that builds the table clears reachable[0..target] first, then
// visits each subsum for each age with two registered reads of the reachable
// memory, then one update. All table work runs through one shared compare
// and subtract path.
module subset_sum_finder #(
  parameter int MAX_CONTACTS = ssf_pkg::MAX_CONTACTS_DEF,
  parameter int MAX_SUM      = ssf_pkg::MAX_SUM_DEF,
  parameter int AGE_BITS     = ssf_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ssf_pkg::IN_DATA_W-1:0]   s_tdata,  // age[7:0], target[21:8], zero pad
  input  logic [ssf_pkg::OPCODE_W-1:0]    s_tuser,  // opcode[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ssf_pkg::OUT_AGE_W-1:0]   m_tdata,  // member_age[7:0]
  output logic [ssf_pkg::STATUS_W-1:0]    m_tuser,  // status[1:0]
  output logic                            m_tlast
);
  import ssf_pkg::*;

  localparam int IDX_W = $clog2(MAX_CONTACTS);
  localparam int CNT_W = $clog2(MAX_CONTACTS + 1);
  localparam int SUM_W = $clog2(MAX_SUM + 1);
  localparam int TOT_W = $clog2(MAX_CONTACTS * ((1 << AGE_BITS) - 1) + 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LRD   = 16'h0002,
    S_LCMP  = 16'h0004,
    S_DONE  = 16'h0008,
    S_CLR   = 16'h0010,
    S_DITEM = 16'h0020,
    S_DAGE  = 16'h0040,
    S_DRD   = 16'h0080,
    S_DCHK  = 16'h0100,
    S_BRD   = 16'h0200,
    S_BFI   = 16'h0400,
    S_BAG   = 16'h0800,
    S_ERD   = 16'h1000,
    S_ELOAD = 16'h2000,
    S_EWAIT = 16'h4000
  } state_t;

  state_t state;

  // stores
  logic [AGE_BITS-1:0] sorted_mem [MAX_CONTACTS];
  logic [AGE_BITS-1:0] order_mem  [MAX_CONTACTS];
  logic [AGE_BITS-1:0] chain_mem  [MAX_CONTACTS];
  logic                reach_mem  [MAX_SUM+1];
  logic [IDX_W-1:0]    first_mem  [MAX_SUM+1];

  logic [CNT_W-1:0]    stored_count;
  logic [TOT_W-1:0]    age_total;
  logic [AGE_BITS-1:0] new_age;
  logic [IDX_W-1:0]    pos;
  logic [CNT_W-1:0]    item;
  logic [AGE_BITS-1:0] cur_age;
  logic [SUM_W-1:0]    sub;
  logic [SUM_W-1:0]    tgt;
  logic                hit;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    ek;
  logic                e_src;   // 1 for load order, 0 for chain
  logic                e_done;

  // read data
  logic [AGE_BITS-1:0] sorted_rd;
  logic [AGE_BITS-1:0] order_rd;
  logic [AGE_BITS-1:0] chain_rd;
  logic                reach_rd1;
  logic                reach_rd2;
  logic [IDX_W-1:0]    first_rd;

  logic [IDX_W-1:0]    sorted_ra;
  logic                sorted_we;
  logic [IDX_W-1:0]    sorted_wa;
  logic [AGE_BITS-1:0] sorted_wd;
  logic [SUM_W-1:0]    diff;
  logic                reach_we;
  logic                reach_wd;
  logic                take;

  logic                in_acc;
  logic                out_acc;
  logic [IN_AGE_W-1:0] in_age;
  logic [TARGET_W-1:0] in_target;

  assign in_acc    = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;
  assign in_age    = s_tdata[IN_AGE_W-1:0];
  assign in_target = s_tdata[IN_AGE_W +: TARGET_W];
  assign s_tready  = (state == S_IDLE);
  assign diff      = sub - SUM_W'(cur_age);

  // subsum update: not yet reachable and age closes it
  assign take = !reach_rd1 && ((32'(cur_age) == 32'(sub)) ||
                ((32'(sub) > 32'(cur_age)) && reach_rd2));

  always_comb begin
    sorted_ra = pos - IDX_W'(1);
    sorted_we = 1'b0;
    sorted_wa = pos;
    sorted_wd = new_age;
    reach_we  = 1'b0;
    reach_wd  = 1'b0;
    unique case (state)
      S_DITEM: sorted_ra = item[IDX_W-1:0];
      S_BFI:   sorted_ra = first_rd;
      S_LRD:   begin
        if (pos == '0) sorted_we = 1'b1;
      end
      S_LCMP:  begin
        sorted_we = 1'b1;
        if (sorted_rd < new_age) sorted_wd = sorted_rd;
      end
      S_CLR:   reach_we = 1'b1;
      S_DCHK:  begin
        reach_we = take;
        reach_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sorted_we) sorted_mem[sorted_wa] <= sorted_wd;
    sorted_rd <= sorted_mem[sorted_ra];
    if (in_acc && (s_tuser == OP_LOAD) && (32'(stored_count) < 32'(MAX_CONTACTS)))
      order_mem[stored_count[IDX_W-1:0]] <= AGE_BITS'(in_age);
    order_rd <= order_mem[ek[IDX_W-1:0]];
    if (state == S_BAG) chain_mem[n[IDX_W-1:0]] <= sorted_rd;
    chain_rd <= chain_mem[ek[IDX_W-1:0]];
    if (reach_we) reach_mem[sub] <= reach_wd;
    if (state == S_DCHK && take) first_mem[sub] <= item[IDX_W-1:0];
    reach_rd1 <= reach_mem[sub];
    reach_rd2 <= reach_mem[diff];
    first_rd  <= first_mem[sub];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      age_total    <= '0;
      m_tvalid     <= 1'b0;
      hit          <= 1'b0;
      e_done       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (s_tuser)
              OP_LOAD: begin
                if (32'(stored_count) < 32'(MAX_CONTACTS)) begin
                  new_age <= AGE_BITS'(in_age);
                  pos     <= stored_count[IDX_W-1:0];
                  state   <= S_LRD;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_QUERY: begin
                m_tdata <= '0;
                m_tlast <= 1'b1;
                e_done  <= 1'b1;
                if (in_target == '0) begin
                  m_tuser  <= ST_ZERO;
                  m_tvalid <= 1'b1;
                  state    <= S_EWAIT;
                end else if (stored_count == '0 ||
                             32'(age_total) < 32'(in_target) ||
                             32'(in_target) > 32'(MAX_SUM)) begin
                  m_tuser  <= ST_NONE;
                  m_tvalid <= 1'b1;
                  state    <= S_EWAIT;
                end else if (32'(age_total) == 32'(in_target)) begin
                  e_src <= 1'b1;
                  ek    <= '0;
                  state <= S_ERD;
                end else begin
                  tgt   <= SUM_W'(in_target);
                  sub   <= SUM_W'(in_target);
                  hit   <= 1'b0;
                  item  <= '0;
                  state <= S_CLR;
                end
              end
              OP_CLEAR: begin
                stored_count <= '0;
                age_total    <= '0;
                state        <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DONE: state <= S_IDLE;
        // insertion: shift smaller ages one place up
        S_LRD: begin
          if (pos == '0) begin
            stored_count <= stored_count + CNT_W'(1);
            age_total    <= age_total + TOT_W'(new_age);
            state        <= S_IDLE;
          end else begin
            state <= S_LCMP;
          end
        end
        S_LCMP: begin
          if (sorted_rd < new_age) begin
            pos   <= pos - IDX_W'(1);
            state <= S_LRD;
          end else begin
            stored_count <= stored_count + CNT_W'(1);
            age_total    <= age_total + TOT_W'(new_age);
            state        <= S_IDLE;
          end
        end
        S_CLR: begin
          if (sub == '0) state <= S_DITEM;
          else sub <= sub - SUM_W'(1);
        end
        S_DITEM: begin
          if (hit) begin
            sub   <= tgt;
            n     <= '0;
            state <= S_BRD;
          end else if (item == stored_count) begin
            m_tuser  <= ST_NONE;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            e_done   <= 1'b1;
            m_tvalid <= 1'b1;
            state    <= S_EWAIT;
          end else begin
            state <= S_DAGE;
          end
        end
        S_DAGE: begin
          cur_age <= sorted_rd;
          sub     <= tgt;
          state   <= S_DRD;
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          if (take && sub == tgt) hit <= 1'b1;
          if (sub == SUM_W'(1)) begin
            item  <= item + CNT_W'(1);
            state <= S_DITEM;
          end else begin
            sub   <= sub - SUM_W'(1);
            state <= S_DRD;
          end
        end
        // walk back from the target
        S_BRD: begin
          if (sub == '0) begin
            e_src <= 1'b0;
            ek    <= n - CNT_W'(1);
            state <= S_ERD;
          end else begin
            state <= S_BFI;
          end
        end
        S_BFI: begin
          if (!reach_rd1 || CNT_W'(first_rd) >= stored_count) begin
            e_src <= 1'b0;
            ek    <= n - CNT_W'(1);
            state <= S_ERD;
          end else begin
            state <= S_BAG;
          end
        end
        S_BAG: begin
          n <= n + CNT_W'(1);
          if (sorted_rd == '0 || 32'(sorted_rd) > 32'(sub) ||
              32'(n) == 32'(MAX_CONTACTS - 1)) begin
            e_src <= 1'b0;
            ek    <= n;
            state <= S_ERD;
          end else begin
            sub   <= sub - SUM_W'(sorted_rd);
            state <= S_BRD;
          end
        end
        S_ERD: state <= S_ELOAD;
        S_ELOAD: begin
          m_tvalid <= 1'b1;
          m_tuser  <= ST_FOUND;
          if (e_src) begin
            m_tdata <= OUT_AGE_W'(order_rd);
            m_tlast <= (ek == stored_count - CNT_W'(1));
            e_done  <= (ek == stored_count - CNT_W'(1));
          end else begin
            m_tdata <= OUT_AGE_W'(chain_rd);
            m_tlast <= (ek == '0);
            e_done  <= (ek == '0);
          end
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_acc) begin
            m_tvalid <= 1'b0;
            if (e_done) begin
              state <= S_IDLE;
            end else begin
              ek    <= e_src ? ek + CNT_W'(1) : ek - CNT_W'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ssf_checker.sv]
// ----------------------------------------------------------------------------
// ssf_checker
// Port level checks for the subset sum finder.
// ----------------------------------------------------------------------------
module ssf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ssf_pkg::OUT_AGE_W-1:0] m_tdata,
  input logic [ssf_pkg::STATUS_W-1:0]  m_tuser,
  input logic                          m_tlast
);
  import ssf_pkg::*;

  // every request leaves the block busy in the cycle after it
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready high right after a request");

  // no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("ready while result pending");

  // zero and none status answers are single zero items
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_FOUND) |-> m_tlast && (m_tdata == '0))
    else $error("status item malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind subset_sum_finder ssf_checker u_ssf_checker (.*);
